FILE: hw/rtl/cce_pkg.sv
// Shared types, constants and elaboration-time tables for the CRC32C combine engine.
// Used by cce_mulmod, cce_ctrl and crc32c_combine_engine_unit; depends on nothing.
package cce_pkg;

  localparam int LENGTH_BITS_DEF = 64;
  localparam int TAB_DEPTH       = 64;
  localparam int TAB_IDX_W       = 6;

  localparam logic [31:0] POLY_REFL   = 32'h82F63B78;
  localparam logic [31:0] X_POW_0     = 32'h80000000;
  localparam logic [31:0] X_POW_8     = 32'h00800000;
  localparam logic [31:0] X_POW_NEG_8 = 32'hfde39562;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL
  } state_t;

  typedef enum logic [1:0] {
    OP_EXTEND = 2'd0,
    OP_APPEND = 2'd1,
    OP_XOR    = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic fin;
  } ctl_t;

  typedef logic [31:0][31:0]        fold_tab_t;
  typedef logic [TAB_DEPTH-1:0][31:0] pow_tab_t;

  function automatic logic [31:0] reduce_c(input logic [63:0] v);
    logic [31:0] r;
    r = v[31:0];
    for (int i = 0; i < 32; i++) begin
      r = r[0] ? ((r >> 1) ^ POLY_REFL) : (r >> 1);
    end
    return r ^ v[63:32];
  endfunction

  function automatic logic [63:0] clmul_c(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] sh;
    logic [63:0] acc;
    sh  = {b, 32'h0};
    acc = '0;
    for (int i = 0; i < 32; i++) begin
      if (a[31-i]) begin
        acc = acc ^ sh;
      end
      sh = sh >> 1;
    end
    return acc;
  endfunction

  function automatic fold_tab_t fold_table();
    fold_tab_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = reduce_c({32'h0, 32'h1 << i});
    end
    return t;
  endfunction

  function automatic pow_tab_t pow_table(input logic [31:0] seed);
    pow_tab_t    t;
    logic [31:0] p;
    p = seed;
    for (int k = 0; k < TAB_DEPTH; k++) begin
      t[k] = p;
      p    = reduce_c(clmul_c(p, p));
    end
    return t;
  endfunction

  localparam fold_tab_t FOLD    = fold_table();
  localparam pow_tab_t  POW_POS = pow_table(X_POW_8);
  localparam pow_tab_t  POW_NEG = pow_table(X_POW_NEG_8);

endpackage

FILE: hw/rtl/cce_mulmod.sv
// Shared carry-less multiply with reduction modulo the reflected CRC32C polynomial.
// Depends on cce_pkg for the fold constants.
module cce_mulmod (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);

  logic [63:0] prod;
  logic [31:0] red;

  always_comb begin
    prod = '0;
    for (int i = 0; i < 32; i++) begin
      if (a[31-i]) begin
        prod = prod ^ ({b, 32'h0} >> i);
      end
    end
  end

  always_comb begin
    red = prod[63:32];
    for (int i = 0; i < 32; i++) begin
      if (prod[i]) begin
        red = red ^ cce_pkg::FOLD[i];
      end
    end
  end

  assign p = red;

endmodule

FILE: hw/rtl/cce_ctrl.sv
// Sequencer for the combine engine: idle, one scan step per length bit, final multiply.
// Depends on cce_pkg for the state and control types.
module cce_ctrl #(
  parameter int LENGTH_BITS = cce_pkg::LENGTH_BITS_DEF,
  localparam int KW         = $clog2(LENGTH_BITS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output cce_pkg::ctl_t ctl,
  output logic [KW-1:0] k
);

  cce_pkg::state_t state;
  cce_pkg::state_t state_next;
  logic            last;

  assign last = (k == KW'(LENGTH_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cce_pkg::ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      if (ctl.load) begin
        k <= '0;
      end else if (ctl.scan) begin
        k <= k + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cce_pkg::ST_IDLE: begin
        if (start) state_next = cce_pkg::ST_SCAN;
      end
      cce_pkg::ST_SCAN: begin
        if (last) state_next = cce_pkg::ST_FINAL;
      end
      cce_pkg::ST_FINAL: begin
        state_next = cce_pkg::ST_IDLE;
      end
      default: begin
        state_next = cce_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    case (state)
      cce_pkg::ST_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      cce_pkg::ST_SCAN: begin
        ctl.scan = 1'b1;
      end
      cce_pkg::ST_FINAL: begin
        ctl.fin = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/crc32c_combine_engine_unit.sv
// Top level of the CRC32C combine engine: operand registers and result register.
// Depends on cce_pkg, cce_mulmod and cce_ctrl.
//
// An item is taken when start is high and busy is low. The engine then scans the
// byte length one bit per cycle through the single shared multiply-reduce unit,
// against constant power tables, and ends with the final multiply. Busy stays high
// through the scan and the final multiply. done is high for a single cycle; crc_out
// is valid from that cycle on until the next item's final multiply, and the receiver
// cannot stall it. A new item may be started in the same cycle that done is high.
module crc32c_combine_engine_unit #(
  parameter int LENGTH_BITS = cce_pkg::LENGTH_BITS_DEF,
  localparam int KW         = $clog2(LENGTH_BITS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic [31:0]        crc_a,
  input  logic [31:0]        crc_b,
  input  logic signed [63:0] length,
  output logic               done,
  output logic [31:0]        crc_out
);

  cce_pkg::ctl_t     ctl;
  logic [KW-1:0]     k;
  cce_pkg::opcode_t  op;
  logic [31:0]       ra;
  logic [31:0]       rb;
  logic [LENGTH_BITS-1:0] mag;
  logic              neg;
  logic [31:0]       acc;

  logic [63:0]       len_u;
  logic [63:0]       len_neg;
  logic              neg_in;
  logic [31:0]       tab_entry;
  logic [31:0]       fin_operand;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [31:0]       mm;
  logic [31:0]       result;

  assign len_u   = $unsigned(length);
  assign len_neg = 64'h0 - len_u;
  assign neg_in  = (cce_pkg::opcode_t'(opcode) == cce_pkg::OP_EXTEND)
                 && (len_u[63] || (len_u == 64'h0));

  assign tab_entry = neg ? cce_pkg::POW_NEG[cce_pkg::TAB_IDX_W'(k)]
                         : cce_pkg::POW_POS[cce_pkg::TAB_IDX_W'(k)];

  always_comb begin
    case (op)
      cce_pkg::OP_EXTEND: fin_operand = ~ra;
      cce_pkg::OP_APPEND: fin_operand = ra;
      default:            fin_operand = 32'hFFFFFFFF;
    endcase
  end

  assign mul_a = ctl.fin ? fin_operand : acc;
  assign mul_b = ctl.fin ? acc : tab_entry;

  cce_mulmod u_mulmod (
    .a (mul_a),
    .b (mul_b),
    .p (mm)
  );

  cce_ctrl #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl),
    .k     (k)
  );

  always_comb begin
    case (op)
      cce_pkg::OP_EXTEND: result = ~mm;
      cce_pkg::OP_APPEND: result = mm ^ rb;
      cce_pkg::OP_XOR:    result = ra ^ rb ^ ~mm;
      default:            result = ra;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op  <= cce_pkg::opcode_t'(opcode);
      ra  <= crc_a;
      rb  <= crc_b;
      neg <= neg_in;
      mag <= neg_in ? len_neg[LENGTH_BITS-1:0] : len_u[LENGTH_BITS-1:0];
      acc <= cce_pkg::X_POW_0;
    end else if (ctl.scan && mag[k]) begin
      acc <= mm;
    end
    if (ctl.fin) begin
      crc_out <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.fin;
    end
  end

endmodule
